[hdl/sorted_priority_queue_unit_assert.svh]
// Assertion macros for the sorted priority queue unit.
// Depends on clk_i and rst_ni being in scope where the macros are used.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spq assertion failed");
// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spq assertion failed");
`else
`define SPQ_ASSERT_NOW(label, ante, cons)
`define SPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/spq_pkg.sv]
// Shared types and constants for the sorted priority queue unit.
// No dependencies; used by spq_cell and sorted_priority_queue_unit.
package spq_pkg;

  localparam int unsigned QueueDepthDef   = 128;
  localparam int unsigned PriorityBitsDef = 10;
  localparam int unsigned PayloadBitsDef  = 16;

  localparam int unsigned CapBits      = 8;
  localparam logic [CapBits-1:0] CapReset = 8'd128;
  localparam int unsigned CountOutBits = 8;
  localparam int unsigned ApbAddrBits  = 3;
  localparam int unsigned ApbDataBits  = 32;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_NONE     = 1'b1
  } reg_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

[hdl/spq_cell.sv]
// One slot of the sorted chain: holds an entry, compares it to the incoming key,
// and loads from itself, its left or right neighbor, or the new entry. Uses spq_pkg.
module spq_cell #(
  parameter int unsigned PRIORITY_BITS = spq_pkg::PriorityBitsDef,
  parameter int unsigned PAYLOAD_BITS  = spq_pkg::PayloadBitsDef,
  parameter int unsigned COUNT_BITS    = 8,
  parameter int unsigned CELL_IDX      = 0
) (
  input  logic                     clk_i,
  input  spq_pkg::cell_ctrl_t      ctrl_i,
  input  logic [COUNT_BITS-1:0]    count_i,
  input  logic [PRIORITY_BITS-1:0] new_prio_i,
  input  logic [PAYLOAD_BITS-1:0]  new_pay_i,
  input  logic [PRIORITY_BITS-1:0] left_prio_i,
  input  logic [PAYLOAD_BITS-1:0]  left_pay_i,
  input  logic                     left_ge_i,
  input  logic [PRIORITY_BITS-1:0] right_prio_i,
  input  logic [PAYLOAD_BITS-1:0]  right_pay_i,
  output logic                     ge_o,
  output logic [PRIORITY_BITS-1:0] prio_o,
  output logic [PAYLOAD_BITS-1:0]  pay_o
);

  logic [PRIORITY_BITS-1:0] prio_q, prio_d;
  logic [PAYLOAD_BITS-1:0]  pay_q, pay_d;
  logic                     occupied;

  assign occupied = COUNT_BITS'(CELL_IDX) < count_i;
  // Entry stays ahead of the new one: occupied and at least as urgent.
  assign ge_o     = occupied && (prio_q >= new_prio_i);

  always_comb begin
    prio_d = prio_q;
    pay_d  = pay_q;
    if (ctrl_i.push && !ge_o) begin
      if (left_ge_i) begin
        // insertion point: take the new entry
        prio_d = new_prio_i;
        pay_d  = new_pay_i;
      end else begin
        prio_d = left_prio_i;
        pay_d  = left_pay_i;
      end
    end else if (ctrl_i.pop) begin
      prio_d = right_prio_i;
      pay_d  = right_pay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    pay_q  <= pay_d;
  end

  assign prio_o = prio_q;
  assign pay_o  = pay_q;

endmodule

[hdl/sorted_priority_queue_unit.sv]
// Sorted priority queue unit: top level with control, configuration port and cell chain.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_unit_assert.svh.
//
//  channel   | direction | handshake                         | carries
//  ----------+-----------+-----------------------------------+-----------------------------
//  s_axis    | in        | s_axis_tvalid & s_axis_tready     | request word
//  m_axis    | out       | m_axis_tvalid & m_axis_tready     | result word
//  apb       | in        | psel & penable & pwrite & pready  | queue_capacity register
//
// Each request is handled in the cycle it is accepted; its result is registered and
// shows in the next cycle. A new request is taken every cycle as long as the result
// register is empty or being drained, so the rate is one word per cycle. Reset clears
// the count (queue empty) and the result valid flag and restores capacity 128; cell
// contents need no reset.
// A stalled result blocks further requests until it is taken.
`include "sorted_priority_queue_unit_assert.svh"

module sorted_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH   = spq_pkg::QueueDepthDef,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PriorityBitsDef,
  parameter int unsigned PAYLOAD_BITS  = spq_pkg::PayloadBitsDef,
  localparam int unsigned InDataBits   = ((PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
  localparam int unsigned OutDataBits  =
    ((PRIORITY_BITS + PAYLOAD_BITS + spq_pkg::CountOutBits + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, lowest bit up: priority_req, payload_data, zero fill
  input  logic [InDataBits-1:0]            s_axis_tdata,
  // tuser: req_type
  input  logic                             s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, lowest bit up: out_priority, out_payload, entry_count, zero fill
  output logic [OutDataBits-1:0]           m_axis_tdata,
  // tuser: status
  output logic [1:0]                       m_axis_tuser,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [spq_pkg::ApbAddrBits-1:0]  paddr,
  input  logic [spq_pkg::ApbDataBits-1:0]  pwdata,
  output logic [spq_pkg::ApbDataBits-1:0]  prdata,
  output logic                             pready
);

  localparam int unsigned CountBits = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CmpBits   =
    (CountBits > spq_pkg::CapBits) ? CountBits : spq_pkg::CapBits;
  localparam int unsigned PadOut    =
    OutDataBits - PRIORITY_BITS - PAYLOAD_BITS - spq_pkg::CountOutBits;

  // ---------------------------------------------------------------- configuration
  logic [spq_pkg::CapBits-1:0] cap_q;
  logic                        cfg_wr;
  spq_pkg::reg_e               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = spq_pkg::reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= spq_pkg::CapReset;
    end else if (cfg_wr && (reg_sel == spq_pkg::REG_CAPACITY)) begin
      cap_q <= pwdata[spq_pkg::CapBits-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      spq_pkg::REG_CAPACITY: prdata = spq_pkg::ApbDataBits'(cap_q);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- request decode
  logic [PRIORITY_BITS-1:0] new_prio;
  logic [PAYLOAD_BITS-1:0]  new_pay;
  spq_pkg::req_e            req;
  logic                     accept;
  logic [CountBits-1:0]     count_q, count_d;
  logic [CmpBits-1:0]       cap_ext, depth_ext, eff_cap;
  logic                     full, empty;
  spq_pkg::cell_ctrl_t      ctrl;

  assign new_prio = s_axis_tdata[PRIORITY_BITS-1:0];
  assign new_pay  = s_axis_tdata[PRIORITY_BITS +: PAYLOAD_BITS];
  assign req      = spq_pkg::req_e'(s_axis_tuser);

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Effective capacity saturates at the chain length.
  assign cap_ext   = CmpBits'(cap_q);
  assign depth_ext = CmpBits'(QUEUE_DEPTH);
  assign eff_cap   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
  assign full      = CmpBits'(count_q) >= eff_cap;
  assign empty     = (count_q == '0);

  assign ctrl.push = accept && (req == spq_pkg::REQ_ENQ) && !full;
  assign ctrl.pop  = accept && (req == spq_pkg::REQ_DEQ) && !empty;

  always_comb begin
    count_d = count_q;
    if (ctrl.push) begin
      count_d = count_q + CountBits'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CountBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // ---------------------------------------------------------------- cell chain
  // Cell 0 holds the head; occupied cells form a prefix sorted by descending priority.
  logic [PRIORITY_BITS-1:0] cell_prio [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]  cell_pay  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   cell_ge;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [PRIORITY_BITS-1:0] l_prio, r_prio;
    logic [PAYLOAD_BITS-1:0]  l_pay, r_pay;
    logic                     l_ge;

    if (i == 0) begin : g_first
      // nothing to the left: an insertion here always takes the new entry
      assign l_prio = new_prio;
      assign l_pay  = new_pay;
      assign l_ge   = 1'b1;
    end else begin : g_inner
      assign l_prio = cell_prio[i-1];
      assign l_pay  = cell_pay[i-1];
      assign l_ge   = cell_ge[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      // shifted-in content is beyond the count and never read
      assign r_prio = cell_prio[i];
      assign r_pay  = cell_pay[i];
    end else begin : g_body
      assign r_prio = cell_prio[i+1];
      assign r_pay  = cell_pay[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS (PRIORITY_BITS),
      .PAYLOAD_BITS  (PAYLOAD_BITS),
      .COUNT_BITS    (CountBits),
      .CELL_IDX      (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .new_prio_i   (new_prio),
      .new_pay_i    (new_pay),
      .left_prio_i  (l_prio),
      .left_pay_i   (l_pay),
      .left_ge_i    (l_ge),
      .right_prio_i (r_prio),
      .right_pay_i  (r_pay),
      .ge_o         (cell_ge[i]),
      .prio_o       (cell_prio[i]),
      .pay_o        (cell_pay[i])
    );
  end

  // ---------------------------------------------------------------- result register
  logic                     out_valid_q;
  spq_pkg::status_e         out_status_q, out_status_d;
  logic [PRIORITY_BITS-1:0] out_prio_q, out_prio_d;
  logic [PAYLOAD_BITS-1:0]  out_pay_q, out_pay_d;
  logic [spq_pkg::CountOutBits-1:0] out_cnt_q;

  always_comb begin
    out_prio_d = '0;
    out_pay_d  = '0;
    if (req == spq_pkg::REQ_ENQ) begin
      out_status_d = full ? spq_pkg::ST_FULL : spq_pkg::ST_ENQ;
    end else if (empty) begin
      out_status_d = spq_pkg::ST_EMPTY;
    end else begin
      out_status_d = spq_pkg::ST_DEQ;
      out_prio_d   = cell_prio[0];
      out_pay_d    = cell_pay[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload of the result: load on every accepted request, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q <= out_status_d;
      out_prio_q   <= out_prio_d;
      out_pay_q    <= out_pay_d;
      out_cnt_q    <= spq_pkg::CountOutBits'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {PadOut'(0), out_cnt_q, out_pay_q, out_prio_q};

  // ---------------------------------------------------------------- checks
  `SPQ_ASSERT_NOW(a_push_pop_excl, 1'b1, !(ctrl.push && ctrl.pop))
  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CountBits'(QUEUE_DEPTH))
  `SPQ_ASSERT_NEXT(a_push_grows, ctrl.push, count_q == $past(count_q) + CountBits'(1))
  `SPQ_ASSERT_NEXT(a_pop_head, ctrl.pop, out_prio_q == $past(cell_prio[0]))
  `SPQ_ASSERT_NEXT(a_full_keeps, accept && (req == spq_pkg::REQ_ENQ) && full,
                   count_q == $past(count_q))

endmodule

[dv/sorted_priority_queue_unit_tb.sv]
// Self-checking bench for sorted_priority_queue_unit: directed table, then random phases.
// Depends on spq_pkg and the RTL of the unit; results are checked against an in-bench predictor.
`timescale 1ns / 100ps

module sorted_priority_queue_unit_tb;

  localparam int unsigned Depth     = spq_pkg::QueueDepthDef;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 400;

  // One stored queue entry and one result word, as the bench sees them.
  typedef struct packed {
    logic [9:0]  prio;
    logic [15:0] pay;
  } spq_entry_t;

  typedef struct packed {
    spq_pkg::status_e status;
    logic [9:0]       prio;
    logic [15:0]      pay;
    logic [7:0]       count;
  } spq_result_t;

  // A row of the directed table: either a capacity write or a request word.
  typedef struct {
    bit            is_cfg;
    logic [7:0]    cap;
    spq_pkg::req_e req;
    logic [9:0]    prio;
    logic [15:0]   pay;
    bit            typed;
    spq_result_t   want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata, lowest bit up: priority_req, payload_data, zero fill
  logic [31:0] s_axis_tdata = '0;
  // tuser: req_type
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata, lowest bit up: out_priority, out_payload, entry_count, zero fill
  logic [39:0] m_axis_tdata;
  // tuser: status
  logic [1:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [spq_pkg::ApbAddrBits-1:0] paddr = '0;
  logic [spq_pkg::ApbDataBits-1:0] pwdata = '0;
  logic [spq_pkg::ApbDataBits-1:0] prdata;
  logic        pready;

  // Predictor state: the entries in service order and the capacity register.
  spq_entry_t  held_q[$];
  logic [7:0]  cap_now = spq_pkg::CapReset;
  spq_result_t awaited_q[$];

  int unsigned errors = 0;
  int unsigned sent_count = 0;
  int unsigned results_seen = 0;
  int unsigned peak_depth = 0;
  int unsigned drops = 0;
  int unsigned empties = 0;
  int unsigned idle_cycles = 0;
  bit          sender_steady = 1'b0;

  sorted_priority_queue_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk_i = ~clk_i;

  // Work out the result of one request and advance the queue copy.
  // Entries sit in descending priority; a new one goes behind every entry of
  // greater or equal priority, so ties leave in arrival order.
  function automatic spq_result_t next_queue_result(spq_pkg::req_e req, logic [9:0] prio,
                                                    logic [15:0] pay);
    spq_result_t res;
    spq_entry_t  ent;
    int          pos;
    int          limit;
    res = '{status: spq_pkg::ST_EMPTY, prio: '0, pay: '0, count: '0};
    // capacities above the store depth saturate at the depth
    limit = (int'(cap_now) > Depth) ? Depth : int'(cap_now);
    if (req == spq_pkg::REQ_ENQ) begin
      if (held_q.size() >= limit) begin
        res.status = spq_pkg::ST_FULL;
        drops++;
      end else begin
        pos = 0;
        while (pos < held_q.size() && held_q[pos].prio >= prio) pos++;
        ent.prio = prio;
        ent.pay = pay;
        held_q.insert(pos, ent);
        res.status = spq_pkg::ST_ENQ;
      end
    end else if (held_q.size() == 0) begin
      // empty dequeue: zero data, state untouched
      res.status = spq_pkg::ST_EMPTY;
      empties++;
    end else begin
      res.prio = held_q[0].prio;
      res.pay = held_q[0].pay;
      void'(held_q.pop_front());
      res.status = spq_pkg::ST_DEQ;
    end
    res.count = 8'(held_q.size());
    if (held_q.size() > peak_depth) peak_depth = held_q.size();
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
    errors++;
  endtask

  // Offer one request word, with an occasional idle cycle first, and hold it
  // until the block takes it. The expectation is queued at the accepting edge.
  task automatic send_request(spq_pkg::req_e req, logic [9:0] prio, logic [15:0] pay,
                              bit typed, spq_result_t want);
    spq_result_t calc;
    if (!sender_steady && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, pay, prio};
    s_axis_tuser <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    calc = next_queue_result(req, prio, pay);
    // typed rows override the predictor, which still advances its state
    awaited_q.push_back(typed ? want : calc);
    sent_count++;
  endtask

  // Drop the request stream, let every outstanding word drain, then write
  // the capacity register through a setup and an access cycle.
  task automatic write_capacity(logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= spq_pkg::ApbAddrBits'(int'(spq_pkg::REG_CAPACITY) * 4);
    pwdata <= spq_pkg::ApbDataBits'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_now = value;
  endtask

  function automatic plan_row_t req_row(spq_pkg::req_e req, int prio, int pay,
                                        bit typed = 1'b0,
                                        spq_pkg::status_e st = spq_pkg::ST_ENQ,
                                        int opri = 0, int opay = 0, int cnt = 0);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.cap = '0;
    r.req = req;
    r.prio = 10'(prio);
    r.pay = 16'(pay);
    r.typed = typed;
    r.want = '{status: st, prio: 10'(opri), pay: 16'(opay), count: 8'(cnt)};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(int cap);
    plan_row_t r;
    r = req_row(spq_pkg::REQ_ENQ, 0, 0);
    r.is_cfg = 1'b1;
    r.cap = 8'(cap);
    return r;
  endfunction

  // Result side: check every accepted word against the oldest expectation,
  // then pick the ready level for the next cycle. One long hold-off lets the
  // request side back up; a window of results runs with no stalls at all.
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin
    spq_result_t want;
    bit          steady;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_q.size() == 0) begin
        $display("result %0d: word with nothing expected", results_seen);
        errors++;
      end else begin
        want = awaited_q.pop_front();
        if (m_axis_tuser != want.status)
          report_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tdata[9:0] != want.prio)
          report_mismatch("out_priority", m_axis_tdata[9:0], want.prio);
        if (m_axis_tdata[25:10] != want.pay)
          report_mismatch("out_payload", m_axis_tdata[25:10], want.pay);
        if (m_axis_tdata[33:26] != want.count)
          report_mismatch("entry_count", m_axis_tdata[33:26], want.count);
        if (m_axis_tdata[39:34] != '0)
          report_mismatch("tdata fill", m_axis_tdata[39:34], 0);
      end
      results_seen++;
    end
    if (!hold_done && results_seen == 150) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    steady = (results_seen >= 320 && results_seen < 420);
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 11);
    end
  end

  // Watchdog: count cycles in which no word moves on any port.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("sorted_priority_queue_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Random phases: capacity, number of requests, enqueue share in percent.
  // The first one, mostly enqueues, has a capacity above the store depth;
  // later ones drain, refill and sit at the capacity extremes.
  int unsigned phase_cap[7] = '{255, 128, 5, 0, 2, 0, 128};
  int unsigned phase_len[7] = '{200, 60, 60, 20, 40, 60, 60};
  int unsigned phase_enq[7] = '{85, 20, 60, 50, 55, 50, 40};

  initial begin
    plan_row_t     plan[$];
    spq_result_t   none;
    spq_pkg::req_e req;
    logic [9:0]    prio;
    none = '0;

    // Directed table: reset state, field extremes, equal-priority order,
    // ignored data on dequeue, zero capacity, capacity lowered under the count.
    plan.push_back(req_row(spq_pkg::REQ_DEQ, 0, 0, 1, spq_pkg::ST_EMPTY, 0, 0, 0));
    plan.push_back(req_row(spq_pkg::REQ_ENQ, 0, 0, 1, spq_pkg::ST_ENQ, 0, 0, 1));
    plan.push_back(req_row(spq_pkg::REQ_ENQ, 1023, 16'hFFFF, 1, spq_pkg::ST_ENQ, 0, 0, 2));
    plan.push_back(req_row(spq_pkg::REQ_ENQ, 512, 16'h1234));
    plan.push_back(req_row(spq_pkg::REQ_ENQ, 512, 16'h5678));
    plan.push_back(req_row(spq_pkg::REQ_DEQ, 1023, 16'hFFFF, 1, spq_pkg::ST_DEQ, 1023,
                           16'hFFFF, 3));
    plan.push_back(req_row(spq_pkg::REQ_DEQ, 0, 0));
    plan.push_back(req_row(spq_pkg::REQ_DEQ, 341, 16'hAAAA));
    plan.push_back(req_row(spq_pkg::REQ_DEQ, 682, 16'h5555));
    plan.push_back(req_row(spq_pkg::REQ_DEQ, 0, 0, 1, spq_pkg::ST_EMPTY, 0, 0, 0));
    plan.push_back(cfg_row(0));
    plan.push_back(req_row(spq_pkg::REQ_ENQ, 1023, 16'hABCD, 1, spq_pkg::ST_FULL, 0, 0, 0));
    plan.push_back(cfg_row(1));
    plan.push_back(req_row(spq_pkg::REQ_ENQ, 300, 1, 1, spq_pkg::ST_ENQ, 0, 0, 1));
    plan.push_back(req_row(spq_pkg::REQ_ENQ, 400, 2, 1, spq_pkg::ST_FULL, 0, 0, 1));
    plan.push_back(cfg_row(3));
    plan.push_back(req_row(spq_pkg::REQ_ENQ, 5, 3));
    plan.push_back(req_row(spq_pkg::REQ_ENQ, 7, 4));
    plan.push_back(cfg_row(1));
    plan.push_back(req_row(spq_pkg::REQ_ENQ, 1023, 5, 1, spq_pkg::ST_FULL, 0, 0, 3));
    plan.push_back(req_row(spq_pkg::REQ_DEQ, 0, 0));
    plan.push_back(req_row(spq_pkg::REQ_DEQ, 0, 0));
    plan.push_back(req_row(spq_pkg::REQ_ENQ, 9, 6, 1, spq_pkg::ST_FULL, 0, 0, 1));
    plan.push_back(req_row(spq_pkg::REQ_DEQ, 0, 0));

    // Hold reset, then release it once.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_capacity(plan[i].cap);
      else send_request(plan[i].req, plan[i].prio, plan[i].pay, plan[i].typed,
                        plan[i].want);
    end

    // Random part: half small priorities so ties are common, half
    // across the whole range. Data fields stay random on dequeues too.
    phase_cap[5] = $urandom_range(1, 128);
    for (int p = 0; p < 7; p++) begin
      write_capacity(8'(phase_cap[p]));
      for (int n = 0; n < phase_len[p]; n++) begin
        sender_steady = (sent_count >= 300 && sent_count < 400);
        req = ($urandom_range(0, 99) < phase_enq[p]) ? spq_pkg::REQ_ENQ : spq_pkg::REQ_DEQ;
        prio = $urandom_range(0, 1) ? 10'($urandom_range(0, 7))
                                    : 10'($urandom_range(0, 1023));
        send_request(req, prio, 16'($urandom_range(0, 65535)), 1'b0, none);
      end
    end

    // Drain: wait for every expected word, then keep the clock running to catch strays.
    s_axis_tvalid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d requests and %0d results, deepest queue %0d entries",
             sent_count, results_seen, peak_depth);
    $display("%0d enqueues refused as full, %0d dequeues on an empty queue, %0d mismatches",
             drops, empties, errors);
    if (errors == 0) begin
      $display("sorted_priority_queue_unit: match");
    end else begin
      $display("sorted_priority_queue_unit: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_unit.sv
dv/sorted_priority_queue_unit_tb.sv
